@@ hdl/assert_macros.svh @@
// Assertion macros for the resolver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/thkr_pkg.sv @@
// Shared types, constants and field helpers of the tap-hold key resolver.
package thkr_pkg;
	localparam int KEY_W         = 10;
	localparam int TIMEOUT_W     = 24;
	localparam int WORD_W        = 54;
	localparam int EV_TIME_W     = 48;
	localparam int OUT_TIME_W    = 48;
	localparam int VAL_W         = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 54;
	localparam int CNT_REG_W     = 3;
	localparam int NUM_WORD_REGS = 4;
	localparam int S_TDATA_W     = 64;
	localparam int M_TDATA_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_EXPIRE  = 3'd5;

	localparam logic [VAL_W-1:0] KV_RELEASE = 2'd0;
	localparam logic [VAL_W-1:0] KV_PRESS   = 2'd1;
	localparam logic             FUNC_TIMER = 1'b1;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_T_SCAN, ST_A_MIN, ST_A_CHK, ST_A_PRO, ST_MATCH,
		ST_P_SCAN, ST_P_END, ST_R_DO, ST_R_TAP, ST_R_CLOSE, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		EK_HOLD_EXP, EK_HOLD_NOW, EK_KEY_DOWN, EK_KEY_UP, EK_HOLD_UP, EK_TAP_DOWN, EK_TAP_UP
	} emit_kind_t;

	typedef struct packed {
		logic       load;
		logic       ptr_inc;
		logic       ptr_clr;
		logic       ptr_ld_slot;
		logic       any_clr;
		logic       min_step;
		logic       promote;
		logic       emit;
		emit_kind_t kind;
		logic       match;
		logic       open_slot;
		logic       close_slot;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic             func;
		logic             auto_exp;
		logic [VAL_W-1:0] val;
		logic             ptr_end;
		logic             cur_pend;
		logic             cur_exp_le_now;
		logic             cur_exp_le_best;
		logic             cur_key_eq;
		logic             any;
		logic             best_gt_now;
		logic             have_cfg;
		logic             have_slot;
		logic             cur_held;
		logic             full;
		logic             can_emit;
		logic             pend_valid;
	} dp_sts_t;

	function automatic key_t w_key(word_t w);
		return w[KEY_W-1:0];
	endfunction

	function automatic key_t w_tap(word_t w);
		return w[2*KEY_W-1:KEY_W];
	endfunction

	function automatic key_t w_hold(word_t w);
		return w[3*KEY_W-1:2*KEY_W];
	endfunction

	function automatic logic [TIMEOUT_W-1:0] w_timeout(word_t w);
		return w[3*KEY_W+TIMEOUT_W-1:3*KEY_W];
	endfunction
endpackage

@@ hdl/thkr_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
module thkr_ctrl import thkr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.kind = EK_HOLD_NOW;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.func == FUNC_TIMER) begin
					state_d = ST_T_SCAN;
				end else if (sts.auto_exp) begin
					state_d = ST_A_MIN;
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_T_SCAN: begin
				if (sts.ptr_end) begin
					state_d = ST_FIN;
				end else if (sts.cur_pend && sts.cur_exp_le_now) begin
					if (sts.can_emit) begin
						cmd.emit    = 1'b1;
						cmd.kind    = EK_HOLD_EXP;
						cmd.promote = 1'b1;
						cmd.ptr_inc = 1'b1;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			ST_A_MIN: begin
				if (sts.ptr_end) begin
					state_d = ST_A_CHK;
				end else begin
					cmd.min_step = 1'b1;
					cmd.ptr_inc  = 1'b1;
				end
			end
			ST_A_CHK: begin
				if (!sts.any || sts.best_gt_now) begin
					state_d = ST_MATCH;
				end else begin
					cmd.ptr_clr = 1'b1;
					state_d     = ST_A_PRO;
				end
			end
			ST_A_PRO: begin
				if (sts.ptr_end) begin
					cmd.ptr_clr = 1'b1;
					cmd.any_clr = 1'b1;
					state_d     = ST_A_MIN;
				end else if (sts.cur_pend && sts.cur_exp_le_best) begin
					if (sts.can_emit) begin
						cmd.emit    = 1'b1;
						cmd.kind    = EK_HOLD_EXP;
						cmd.promote = 1'b1;
						cmd.ptr_inc = 1'b1;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				if (sts.val == KV_RELEASE) begin
					cmd.ptr_ld_slot = 1'b1;
					state_d         = ST_R_DO;
				end else if (sts.val == KV_PRESS) begin
					cmd.ptr_clr = 1'b1;
					state_d     = ST_P_SCAN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_P_SCAN: begin
				if (sts.ptr_end) begin
					state_d = ST_P_END;
				end else if (sts.cur_pend && !sts.cur_key_eq) begin
					if (sts.can_emit) begin
						cmd.emit    = 1'b1;
						cmd.kind    = EK_HOLD_NOW;
						cmd.promote = 1'b1;
						cmd.ptr_inc = 1'b1;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			ST_P_END: begin
				if (sts.have_cfg) begin
					cmd.open_slot = !sts.have_slot && !sts.full;
					state_d       = ST_FIN;
				end else if (sts.can_emit) begin
					cmd.emit = 1'b1;
					cmd.kind = EK_KEY_DOWN;
					state_d  = ST_FIN;
				end
			end
			ST_R_DO: begin
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					if (!sts.have_slot) begin
						cmd.kind = EK_KEY_UP;
						state_d  = ST_FIN;
					end else if (sts.cur_held) begin
						cmd.kind = EK_HOLD_UP;
						state_d  = ST_R_CLOSE;
					end else begin
						cmd.kind = EK_TAP_DOWN;
						state_d  = ST_R_TAP;
					end
				end
			end
			ST_R_TAP: begin
				if (sts.can_emit) begin
					cmd.emit = 1'b1;
					cmd.kind = EK_TAP_UP;
					state_d  = ST_R_CLOSE;
				end
			end
			ST_R_CLOSE: begin
				cmd.close_slot = 1'b1;
				state_d        = ST_FIN;
			end
			ST_FIN: begin
				if (sts.can_emit) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

@@ hdl/thkr_datapath.sv @@
// Datapath: configuration registers, open-slot table, scan unit and result buffer.
module thkr_datapath import thkr_pkg::*; #(
	parameter int NUM_ENTRIES = 4,
	parameter int TIME_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [S_TDATA_W-1:0]  in_tdata,
	input  logic                  in_tuser,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [M_TDATA_W-1:0]  out_tdata,
	output logic                  out_tlast,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts
);
	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
	localparam int EXP_W = TIME_BITS + 1;

	logic [CNT_REG_W-1:0] entry_count_q;
	logic                 auto_q;
	word_t                word_q [NUM_ENTRIES];

	logic                 func_q;
	logic [TIME_BITS-1:0] now_q;
	key_t                 code_q;
	logic [VAL_W-1:0]     val_q;

	logic [CNT_W-1:0]       open_cnt_q;
	logic [IDX_W-1:0]       slot_idx_q  [NUM_ENTRIES];
	logic [TIME_BITS-1:0]   slot_time_q [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] slot_hold_q;

	logic [CNT_W-1:0] ptr_q;
	logic [EXP_W-1:0] best_q;
	logic             any_q;
	logic             have_cfg_q;
	logic [IDX_W-1:0] cfg_q;
	logic             have_slot_q;

	logic                  pend_v_q;
	key_t                  pend_code_q;
	logic                  pend_val_q;
	logic [OUT_TIME_W-1:0] pend_time_q;
	logic                  out_v_q;
	key_t                  out_code_q;
	logic                  out_val_q;
	logic [OUT_TIME_W-1:0] out_time_q;
	logic                  out_last_q;

	logic [IDX_W-1:0]                cur;
	logic [IDX_W-1:0]                cur_idx;
	word_t                           cur_word;
	logic [EXP_W-1:0]                cur_exp;
	logic [EXP_W-1:0]                now_ext;
	logic [EXP_W+OUT_TIME_W-1:0]     exp_wide;
	logic [TIME_BITS+OUT_TIME_W-1:0] now_wide;
	logic [TIME_BITS+EV_TIME_W-1:0]  in_time_wide;
	logic [NUM_ENTRIES-1:0]          key_hit;
	logic [NUM_ENTRIES-1:0]          cfg_hit;
	logic [NUM_ENTRIES-1:0]          slot_hit;
	logic                            have_cfg_c;
	logic [IDX_W-1:0]                cfg_c;
	logic                            have_slot_c;
	logic [IDX_W-1:0]                slot_c;
	key_t                            em_code;
	logic                            em_val;
	logic [OUT_TIME_W-1:0]           em_time;
	logic                            move;

	assign cur          = ptr_q[IDX_W-1:0];
	assign cur_idx      = slot_idx_q[cur];
	assign cur_word     = word_q[cur_idx];
	assign cur_exp      = {1'b0, slot_time_q[cur]} + EXP_W'(w_timeout(cur_word));
	assign now_ext      = {1'b0, now_q};
	assign exp_wide     = {{OUT_TIME_W{1'b0}}, cur_exp};
	assign now_wide     = {{OUT_TIME_W{1'b0}}, now_q};
	assign in_time_wide = {{TIME_BITS{1'b0}}, in_tdata[EV_TIME_W-1:0]};

	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			key_hit[i] = (w_key(word_q[i]) == code_q);
			cfg_hit[i] = (i < int'(entry_count_q)) && key_hit[i];
		end
		for (int s = 0; s < NUM_ENTRIES; s++) begin
			slot_hit[s] = (CNT_W'(s) < open_cnt_q) && key_hit[slot_idx_q[s]];
		end
	end

	always_comb begin
		have_cfg_c  = 1'b0;
		cfg_c       = '0;
		have_slot_c = 1'b0;
		slot_c      = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			if (cfg_hit[i]) begin
				have_cfg_c = 1'b1;
				cfg_c      = IDX_W'(i);
			end
			if (slot_hit[i]) begin
				have_slot_c = 1'b1;
				slot_c      = IDX_W'(i);
			end
		end
	end

	always_comb begin
		em_code = code_q;
		em_val  = 1'b1;
		em_time = now_wide[OUT_TIME_W-1:0];
		unique case (cmd.kind)
			EK_HOLD_EXP: begin
				em_code = w_hold(cur_word);
				em_time = exp_wide[OUT_TIME_W-1:0];
			end
			EK_HOLD_NOW: begin
				em_code = w_hold(cur_word);
			end
			EK_KEY_DOWN: begin
				em_code = code_q;
			end
			EK_KEY_UP: begin
				em_val = 1'b0;
			end
			EK_HOLD_UP: begin
				em_code = w_hold(cur_word);
				em_val  = 1'b0;
			end
			EK_TAP_DOWN: begin
				em_code = w_tap(cur_word);
			end
			EK_TAP_UP: begin
				em_code = w_tap(cur_word);
				em_val  = 1'b0;
			end
			default: begin
				em_code = code_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			auto_q        <= 1'b0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				word_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_ENTRY_COUNT) begin
				entry_count_q <= cfg_data[CNT_REG_W-1:0];
			end
			if (cfg_index == REG_AUTO_EXPIRE) begin
				auto_q <= cfg_data[0];
			end
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (i < NUM_WORD_REGS && cfg_index == REG_ENTRY_WORD_0 + CFG_IDX_W'(i)) begin
					word_q[i] <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_tuser;
			now_q  <= in_time_wide[TIME_BITS-1:0];
			code_q <= in_tdata[EV_TIME_W +: KEY_W];
			val_q  <= in_tdata[EV_TIME_W+KEY_W +: VAL_W];
		end
		if (cmd.min_step && !slot_hold_q[cur] && (!any_q || cur_exp < best_q)) begin
			best_q <= cur_exp;
		end
		if (cmd.match) begin
			cfg_q <= cfg_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			any_q       <= 1'b0;
			have_cfg_q  <= 1'b0;
			have_slot_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_ld_slot) begin
				ptr_q <= have_slot_c ? CNT_W'(slot_c) : '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.load || cmd.any_clr) begin
				any_q <= 1'b0;
			end else if (cmd.min_step && !slot_hold_q[cur]) begin
				any_q <= 1'b1;
			end
			if (cmd.match) begin
				have_cfg_q  <= have_cfg_c;
				have_slot_q <= have_slot_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cnt_q  <= '0;
			slot_hold_q <= '0;
		end else if (cmd.open_slot) begin
			open_cnt_q                          <= open_cnt_q + 1'b1;
			slot_hold_q[open_cnt_q[IDX_W-1:0]] <= 1'b0;
		end else if (cmd.close_slot) begin
			open_cnt_q <= open_cnt_q - 1'b1;
			for (int s = 0; s < NUM_ENTRIES - 1; s++) begin
				if (CNT_W'(s) >= ptr_q) begin
					slot_hold_q[s] <= slot_hold_q[s+1];
				end
			end
		end else if (cmd.promote) begin
			slot_hold_q[cur] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.open_slot) begin
			slot_idx_q[open_cnt_q[IDX_W-1:0]]  <= cfg_q;
			slot_time_q[open_cnt_q[IDX_W-1:0]] <= now_q;
		end else if (cmd.close_slot) begin
			for (int s = 0; s < NUM_ENTRIES - 1; s++) begin
				if (CNT_W'(s) >= ptr_q) begin
					slot_idx_q[s]  <= slot_idx_q[s+1];
					slot_time_q[s] <= slot_time_q[s+1];
				end
			end
		end
	end

	assign move = (cmd.emit || cmd.finish) && pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_code_q <= pend_code_q;
			out_val_q  <= pend_val_q;
			out_time_q <= pend_time_q;
			out_last_q <= cmd.finish;
		end
		if (cmd.emit) begin
			pend_code_q <= em_code;
			pend_val_q  <= em_val;
			pend_time_q <= em_time;
		end
	end

	assign out_valid = out_v_q;
	assign out_tdata = M_TDATA_W'({out_time_q, out_val_q, out_code_q});
	assign out_tlast = out_last_q;

	assign sts.func            = func_q;
	assign sts.auto_exp        = auto_q;
	assign sts.val             = val_q;
	assign sts.ptr_end         = (ptr_q >= open_cnt_q);
	assign sts.cur_pend        = !slot_hold_q[cur];
	assign sts.cur_exp_le_now  = (cur_exp <= now_ext);
	assign sts.cur_exp_le_best = (cur_exp <= best_q);
	assign sts.cur_key_eq      = key_hit[cur_idx];
	assign sts.any             = any_q;
	assign sts.best_gt_now     = (best_q > now_ext);
	assign sts.have_cfg        = have_cfg_q;
	assign sts.have_slot       = have_slot_q;
	assign sts.cur_held        = slot_hold_q[cur];
	assign sts.full            = (open_cnt_q == CNT_W'(NUM_ENTRIES));
	assign sts.can_emit        = !pend_v_q || !out_v_q || out_ready;
	assign sts.pend_valid      = pend_v_q;
endmodule

@@ hdl/tap_hold_key_resolver_unit.sv @@
// Tap-hold key resolver top level; one item is in flight at a time.
// How long an item stays busy depends on its path (timer check, press, repeat or unknown,
// release of a plain key, a held entry or a tap) and grows with the open-slot count; auto-expiry
// adds to each key event and more for every round that promotes. A full output stalls the item.
// Reset clears the configuration registers, the open-slot count and hold flags, and the output.
`include "assert_macros.svh"
module tap_hold_key_resolver_unit import thkr_pkg::*; #(
	parameter int NUM_ENTRIES = 4,
	parameter int TIME_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// event_time [47:0], key_code [57:48], key_value [59:58], zero fill above.
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// func [0].
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_code [9:0], out_value [10], out_time [58:11], zero fill above.
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	thkr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	thkr_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tlast (m_axis_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

	`ASSERT_IMPLY(a_emit_room, clk, arst_n, cmd.emit, sts.can_emit)
	`ASSERT_IMPLY(a_idle_empty, clk, arst_n, s_axis_tready, !sts.pend_valid)
	`ASSERT_IMPLY(a_open_room, clk, arst_n, cmd.open_slot, !sts.full && !sts.have_slot)
	`ASSERT_IMPLY(a_close_hit, clk, arst_n, cmd.close_slot, sts.have_slot)
	`ASSERT_NEXT(a_finish_idle, clk, arst_n, cmd.finish, s_axis_tready)
endmodule

@@ tb/tap_hold_event_checker.sv @@
// Checker that predicts the resolved key events and compares them with the output stream.
`timescale 1ns / 1ps
module tap_hold_event_checker import thkr_pkg::*; #(
	parameter int NUM_ENTRIES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    backlog
);
	localparam logic OUT_RELEASE = 1'b0;
	localparam logic OUT_PRESS   = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]      code;
		logic                  value;
		logic [OUT_TIME_W-1:0] stamp;
		logic                  last;
	} key_event_t;

	key_event_t expected_events[$];
	key_event_t step_events[$];

	logic [CNT_REG_W-1:0] entries_used_reg;
	word_t                entry_word[NUM_ENTRIES];
	logic                 auto_expire;

	int                   open_n;
	int                   slot_entry[NUM_ENTRIES];
	logic [EV_TIME_W-1:0] slot_down[NUM_ENTRIES];
	logic                 slot_held[NUM_ENTRIES];

	task automatic flag_mismatch(input string msg);
		fail_count++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	function automatic word_t slot_word(int s);
		return entry_word[slot_entry[s] % NUM_ENTRIES];
	endfunction

	// Expiry keeps one extra bit so that a timeout past the top of the time range never wraps.
	function automatic logic [EV_TIME_W:0] slot_expiry(int s);
		word_t w;
		w = slot_word(s);
		return {1'b0, slot_down[s]} + w[3*KEY_W +: TIMEOUT_W];
	endfunction

	function automatic void emit_event(logic [KEY_W-1:0] code, logic value,
			logic [EV_TIME_W:0] stamp);
		key_event_t ev;
		if (step_events.size() < NUM_ENTRIES + 1) begin
			ev.code = code;
			ev.value = value;
			ev.stamp = stamp[OUT_TIME_W-1:0];
			ev.last = 1'b0;
			step_events.insert(step_events.size(), ev);
		end
	endfunction

	function automatic void promote_due(logic [EV_TIME_W:0] limit);
		word_t              w;
		logic [EV_TIME_W:0] due;
		for (int s = 0; s < open_n; s++) begin
			if (!slot_held[s]) begin
				w = slot_word(s);
				due = slot_expiry(s);
				if (due <= limit) begin
					emit_event(w[2*KEY_W +: KEY_W], OUT_PRESS, due);
					slot_held[s] = 1'b1;
				end
			end
		end
	endfunction

	// Promotes the earliest-expiring pending group first, repeating while any is overdue.
	function automatic void promote_overdue(logic [EV_TIME_W-1:0] now);
		logic               found;
		logic               again;
		logic [EV_TIME_W:0] best;
		logic [EV_TIME_W:0] due;
		again = 1'b1;
		while (again) begin
			found = 1'b0;
			best = '0;
			for (int s = 0; s < open_n; s++) begin
				if (!slot_held[s]) begin
					due = slot_expiry(s);
					if (!found || due < best) begin
						best = due;
					end
					found = 1'b1;
				end
			end
			again = found && (best <= {1'b0, now});
			if (again) begin
				promote_due(best);
			end
		end
	endfunction

	function automatic void resolve_event(logic is_timer, logic [EV_TIME_W-1:0] now,
			logic [KEY_W-1:0] code, logic [VAL_W-1:0] val);
		int         used;
		int         cfg;
		int         slot;
		logic       have_cfg;
		logic       have_slot;
		word_t      w;
		key_event_t ev;
		step_events.delete();
		if (is_timer == FUNC_TIMER) begin
			promote_due({1'b0, now});
		end else begin
			if (auto_expire) begin
				promote_overdue(now);
			end
			used = (entries_used_reg > NUM_ENTRIES) ? NUM_ENTRIES : int'(entries_used_reg);
			have_cfg = 1'b0;
			cfg = 0;
			for (int i = 0; i < used && !have_cfg; i++) begin
				if (entry_word[i][0 +: KEY_W] == code) begin
					cfg = i;
					have_cfg = 1'b1;
				end
			end
			have_slot = 1'b0;
			slot = 0;
			for (int s = 0; s < open_n && !have_slot; s++) begin
				w = slot_word(s);
				if (w[0 +: KEY_W] == code) begin
					slot = s;
					have_slot = 1'b1;
				end
			end
			if (val == KV_PRESS) begin
				for (int s = 0; s < open_n; s++) begin
					w = slot_word(s);
					if (!slot_held[s] && w[0 +: KEY_W] != code) begin
						emit_event(w[2*KEY_W +: KEY_W], OUT_PRESS, {1'b0, now});
						slot_held[s] = 1'b1;
					end
				end
				if (have_cfg) begin
					if (!have_slot && open_n < NUM_ENTRIES) begin
						slot_entry[open_n] = cfg;
						slot_down[open_n] = now;
						slot_held[open_n] = 1'b0;
						open_n++;
					end
				end else begin
					emit_event(code, OUT_PRESS, {1'b0, now});
				end
			end else if (val == KV_RELEASE) begin
				if (have_slot) begin
					w = slot_word(slot);
					if (slot_held[slot]) begin
						emit_event(w[2*KEY_W +: KEY_W], OUT_RELEASE, {1'b0, now});
					end else begin
						emit_event(w[KEY_W +: KEY_W], OUT_PRESS, {1'b0, now});
						emit_event(w[KEY_W +: KEY_W], OUT_RELEASE, {1'b0, now});
					end
					for (int s = slot; s + 1 < open_n; s++) begin
						slot_entry[s] = slot_entry[s + 1];
						slot_down[s] = slot_down[s + 1];
						slot_held[s] = slot_held[s + 1];
					end
					open_n--;
				end else begin
					emit_event(code, OUT_RELEASE, {1'b0, now});
				end
			end
		end
		foreach (step_events[i]) begin
			ev = step_events[i];
			ev.last = (i == step_events.size() - 1);
			expected_events.insert(expected_events.size(), ev);
		end
	endfunction

	function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		int word_idx;
		if (idx == REG_ENTRY_COUNT) begin
			entries_used_reg = data[CNT_REG_W-1:0];
		end else if (idx >= REG_ENTRY_WORD_0 && idx < REG_ENTRY_WORD_0 + NUM_WORD_REGS) begin
			word_idx = idx - REG_ENTRY_WORD_0;
			if (word_idx < NUM_ENTRIES) begin
				entry_word[word_idx] = data[WORD_W-1:0];
			end
		end else if (idx == REG_AUTO_EXPIRE) begin
			auto_expire = data[0];
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		key_event_t            want;
		logic [KEY_W-1:0]      got_code;
		logic                  got_value;
		logic [OUT_TIME_W-1:0] got_stamp;
		if (!arst_n) begin
			entries_used_reg = '0;
			auto_expire = 1'b0;
			open_n = 0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				entry_word[i] = '0;
				slot_held[i] = 1'b0;
			end
			expected_events.delete();
			backlog = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_code = m_axis_tdata[0 +: KEY_W];
				got_value = m_axis_tdata[KEY_W];
				got_stamp = m_axis_tdata[KEY_W + 1 +: OUT_TIME_W];
				if (expected_events.size() == 0) begin
					flag_mismatch($sformatf("unexpected transfer code %0d value %0d at %0d",
						got_code, got_value, got_stamp));
				end else begin
					want = expected_events.pop_front();
					if (got_code != want.code) begin
						flag_mismatch($sformatf("out_code %0d, expected %0d", got_code, want.code));
					end
					if (got_value != want.value) begin
						flag_mismatch($sformatf("out_value %0d, expected %0d (code %0d)",
							got_value, want.value, want.code));
					end
					if (got_stamp != want.stamp) begin
						flag_mismatch($sformatf("out_time %0d, expected %0d (code %0d)",
							got_stamp, want.stamp, want.code));
					end
					if (m_axis_tlast !== want.last) begin
						flag_mismatch($sformatf("tlast %b, expected %b (code %0d)",
							m_axis_tlast, want.last, want.code));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_config(cfg_index, cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				resolve_event(s_axis_tuser, s_axis_tdata[0 +: EV_TIME_W],
					s_axis_tdata[EV_TIME_W +: KEY_W], s_axis_tdata[EV_TIME_W + KEY_W +: VAL_W]);
			end
			backlog = expected_events.size();
		end
	end
endmodule

@@ tb/tb_tap_hold_key_resolver_unit.sv @@
// Testbench top: drives key events and register writes into the resolver and gives the verdict.
`timescale 1ns / 1ps
module tb_tap_hold_key_resolver_unit import thkr_pkg::*; ();
	localparam logic             FUNC_KEY      = ~FUNC_TIMER;
	localparam logic [VAL_W-1:0] KV_REPEAT     = 2'd2;
	localparam logic [VAL_W-1:0] KV_UNKNOWN    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = REG_AUTO_EXPIRE + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = REG_AUTO_EXPIRE + 3'd2;
	localparam int MAX_KEY        = 767;
	localparam int SETTLE_CYCLES  = 128;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 13;
	localparam logic [EV_TIME_W-1:0] TOP_TIME = {EV_TIME_W{1'b1}};
	localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT = {TIMEOUT_W{1'b1}};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    backlog;

	logic                  steady;
	logic [EV_TIME_W-1:0]  clock_us;
	key_t                  phase_keys[NUM_WORD_REGS];
	key_t                  down_keys[$];

	tap_hold_key_resolver_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tap_hold_event_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.backlog(backlog)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
	end

	initial begin
		#2_000_000;
		$display("tb_tap_hold_key_resolver_unit failed");
		$finish;
	end

	function automatic word_t pack_word(key_t key, key_t tap, key_t hold,
			logic [TIMEOUT_W-1:0] timeout);
		return {timeout, hold, tap, key};
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_config(input logic [CNT_REG_W-1:0] count, input logic auto_exp,
			input word_t words[NUM_WORD_REGS], input logic spares);
		for (int i = 0; i < NUM_WORD_REGS; i++) begin
			write_reg(REG_ENTRY_WORD_0 + CFG_IDX_W'(i), words[i]);
		end
		write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(count));
		write_reg(REG_AUTO_EXPIRE, CFG_DATA_W'(auto_exp));
		if (spares) begin
			write_reg(REG_SPARE_A, {CFG_DATA_W{1'b1}});
			write_reg(REG_SPARE_B, CFG_DATA_W'({$urandom(), $urandom()}));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_event(input logic is_timer, input logic [EV_TIME_W-1:0] stamp,
			input key_t key, input logic [VAL_W-1:0] val);
		while (!steady && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= is_timer;
		s_axis_tdata <= {{(S_TDATA_W - EV_TIME_W - KEY_W - VAL_W){1'b0}}, val, key, stamp};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// An item may still be in flight without any result owed, so the task keeps waiting after the drain.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (backlog != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_event();
		int               r;
		int               pick;
		logic             seen;
		logic             is_timer;
		key_t             key;
		logic [VAL_W-1:0] val;
		clock_us += $urandom_range(0, 300);
		r = $urandom_range(0, 99);
		is_timer = FUNC_KEY;
		if (r < 15) begin
			is_timer = FUNC_TIMER;
			key = key_t'($urandom_range(0, MAX_KEY));
			val = VAL_W'($urandom_range(0, 3));
		end else if (down_keys.size() > 0 && (r < 55 || down_keys.size() > 6)) begin
			pick = $urandom_range(0, down_keys.size() - 1);
			key = down_keys[pick];
			down_keys.delete(pick);
			val = KV_RELEASE;
		end else begin
			if ($urandom_range(0, 9) < 6) begin
				key = phase_keys[$urandom_range(0, NUM_WORD_REGS - 1)];
			end else begin
				key = key_t'($urandom_range(0, MAX_KEY));
			end
			r = $urandom_range(0, 99);
			if (r < 80) begin
				val = KV_PRESS;
				seen = 1'b0;
				foreach (down_keys[i]) begin
					if (down_keys[i] == key) begin
						seen = 1'b1;
					end
				end
				if (!seen) begin
					down_keys.insert(down_keys.size(), key);
				end
			end else if (r < 90) begin
				val = KV_REPEAT;
			end else if (r < 95) begin
				val = KV_UNKNOWN;
			end else begin
				val = KV_RELEASE;
			end
		end
		send_event(is_timer, clock_us, key, val);
	endtask

	task automatic random_phase(input int phase);
		logic [CNT_REG_W-1:0] count;
		word_t                words[NUM_WORD_REGS];
		int                   r;
		logic [TIMEOUT_W-1:0] timeout;
		count = (phase == 0) ? '0 : CNT_REG_W'($urandom_range(0, 7));
		for (int i = 0; i < NUM_WORD_REGS; i++) begin
			r = $urandom_range(0, 9);
			if (i > 0 && r == 0) begin
				phase_keys[i] = phase_keys[0];
			end else begin
				phase_keys[i] = key_t'($urandom_range(0, MAX_KEY));
			end
			if (r == 1) begin
				timeout = '0;
			end else if (r == 2) begin
				timeout = MAX_TIMEOUT;
			end else begin
				timeout = TIMEOUT_W'($urandom_range(20, 400));
			end
			words[i] = pack_word(phase_keys[i], key_t'($urandom_range(0, 1023)),
				key_t'($urandom_range(0, 1023)), timeout);
		end
		load_config(count, 1'($urandom_range(0, 1)), words, $urandom_range(0, 3) == 0);
		if ($urandom_range(0, 3) == 0) begin
			clock_us = EV_TIME_W'({$urandom(), $urandom()});
		end
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			random_event();
		end
		wait_drain();
	endtask

	initial begin
		word_t words[NUM_WORD_REGS];
		arst_n = 1'b0;
		steady = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		clock_us = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Taps, holds by another key and by timer, repeats, and expiry past the top of time.
		words[0] = pack_word(10'd30, 10'd100, 10'd200, TIMEOUT_W'(1000));
		words[1] = pack_word(10'd31, 10'd101, 10'd201, MAX_TIMEOUT);
		words[2] = {WORD_W{1'b1}};
		words[3] = '0;
		load_config(3'd2, 1'b0, words, 1'b1);
		send_event(FUNC_KEY, 48'd0, key_t'(MAX_KEY), KV_PRESS);
		send_event(FUNC_KEY, 48'd10, key_t'(MAX_KEY), KV_RELEASE);
		send_event(FUNC_KEY, 48'd1000, 10'd30, KV_PRESS);
		send_event(FUNC_KEY, 48'd1100, 10'd30, KV_RELEASE);
		send_event(FUNC_KEY, 48'd2000, 10'd30, KV_PRESS);
		send_event(FUNC_KEY, 48'd2050, 10'd5, KV_PRESS);
		send_event(FUNC_KEY, 48'd2060, 10'd5, KV_RELEASE);
		send_event(FUNC_KEY, 48'd2100, 10'd30, KV_RELEASE);
		send_event(FUNC_KEY, 48'd3000, 10'd30, KV_PRESS);
		send_event(FUNC_TIMER, 48'd3500, 10'd0, KV_RELEASE);
		send_event(FUNC_TIMER, 48'd4000, key_t'(MAX_KEY), KV_UNKNOWN);
		send_event(FUNC_KEY, 48'd4001, 10'd30, KV_REPEAT);
		send_event(FUNC_KEY, 48'd4003, 10'd30, KV_PRESS);
		send_event(FUNC_KEY, 48'd4100, 10'd30, KV_RELEASE);
		send_event(FUNC_KEY, TOP_TIME - 48'd15, 10'd31, KV_PRESS);
		send_event(FUNC_TIMER, TOP_TIME, key_t'(MAX_KEY), KV_UNKNOWN);
		send_event(FUNC_KEY, TOP_TIME, 10'd31, KV_RELEASE);
		wait_drain();

		// All four entries open with auto-expiry on and an entry count above the table size.
		words[0] = pack_word(10'd40, 10'd110, 10'd210, TIMEOUT_W'(0));
		words[1] = pack_word(10'd41, 10'd111, 10'd211, TIMEOUT_W'(10));
		words[2] = pack_word(10'd42, 10'd112, 10'd212, TIMEOUT_W'(10));
		words[3] = pack_word(10'd43, 10'd113, 10'd213, TIMEOUT_W'(20));
		load_config(3'd7, 1'b1, words, 1'b0);
		send_event(FUNC_KEY, 48'd100, 10'd40, KV_PRESS);
		send_event(FUNC_KEY, 48'd105, 10'd41, KV_PRESS);
		send_event(FUNC_KEY, 48'd110, 10'd42, KV_PRESS);
		send_event(FUNC_KEY, 48'd112, 10'd43, KV_PRESS);
		send_event(FUNC_KEY, 48'd140, 10'd43, KV_RELEASE);
		send_event(FUNC_KEY, 48'd150, 10'd41, KV_RELEASE);
		send_event(FUNC_KEY, 48'd151, 10'd40, KV_RELEASE);
		send_event(FUNC_KEY, 48'd152, 10'd42, KV_RELEASE);
		wait_drain();

		clock_us = 48'd10_000;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			steady <= (p == 2);
			random_phase(p);
		end

		if (fail_count == 0) begin
			$display("tb_tap_hold_key_resolver_unit passed");
		end else begin
			$display("tb_tap_hold_key_resolver_unit failed");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/thkr_pkg.sv
hdl/thkr_ctrl.sv
hdl/thkr_datapath.sv
hdl/tap_hold_key_resolver_unit.sv
tb/tap_hold_event_checker.sv
tb/tb_tap_hold_key_resolver_unit.sv
